/* rtl/core/char_class_tokenizer_top_macros.svh */
// assertion macros for the character class tokenizer
// used by rtl modules that carry concurrent checks, no other dependencies
`ifndef CHAR_CLASS_TOKENIZER_TOP_MACROS_SVH
`define CHAR_CLASS_TOKENIZER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// check clocked on clk_i, masked while rst_ni is low
`define CCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check clocked on clk_i, also active during reset
`define CCT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define CCT_ASSERT(lbl, prop, msg)
`define CCT_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

/* rtl/core/cct_pkg.sv */
// shared constants and types for the character class tokenizer
// no dependencies
`default_nettype none

package cct_pkg;

  localparam int TOKEN_LEN  = 64;
  localparam int MAX_TOKENS = 256;

  localparam int BYTE_W    = 8;
  localparam int CLS_W     = 3;
  localparam int ACT_W     = 2;
  localparam int TBL_DEPTH = 256;

  // internal counters, sized to hold their saturation value
  localparam int SLOT_W = $clog2(MAX_TOKENS + 1);
  localparam int COL_W  = $clog2(TOKEN_LEN + 1);

  // result field widths
  localparam int SLOT_FW = 8;
  localparam int COL_FW  = 6;
  localparam int CNT_FW  = 9;
  localparam int CNT_MAX = (1 << CNT_FW) - 1;

  localparam int MAX_RES = 4;
  localparam int RES_IW  = $clog2(MAX_RES);
  localparam int RES_CW  = $clog2(MAX_RES + 1);

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;

  localparam logic [BYTE_W-1:0] BACKSLASH = 8'h5C;

  // action codes
  typedef logic [ACT_W-1:0] action_t;
  localparam action_t ACT_LOAD = 2'd0;
  localparam action_t ACT_BYTE = 2'd1;
  localparam action_t ACT_EOL  = 2'd2;

  // byte classes
  typedef logic [CLS_W-1:0] cls_t;
  localparam cls_t CLS_LETTER = 3'd0;
  localparam cls_t CLS_IGNORE = 3'd1;
  localparam cls_t CLS_DELIM  = 3'd2;
  localparam cls_t CLS_SWAP   = 3'd3;
  localparam cls_t CLS_QUOTE  = 3'd4;

  // result kinds
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    action_t           action;
    logic [BYTE_W-1:0] char_byte;
    cls_t              cls;
  } item_t;

  typedef struct packed {
    logic               kind;
    logic [SLOT_FW-1:0] slot;
    logic [COL_FW-1:0]  column;
    logic [BYTE_W-1:0]  value;
    logic [CNT_FW-1:0]  tok_cnt;
    logic               overflow;
    logic               last;
  } res_t;

  typedef res_t [MAX_RES-1:0] res_arr_t;

endpackage

`default_nettype wire

/* rtl/core/cct_ram.sv */
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module cct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cct_front.sv */
// input stage: class table ram with per-entry valid bits and the item register
// depends on cct_pkg and cct_ram
`default_nettype none

module cct_front import cct_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
  input  wire logic [ACT_W-1:0]      s_axis_tuser,
  input  wire logic                  fire_i,
  output logic                       item_vld_o,
  output item_t                      item_o
);

  logic                  acc;
  logic [BYTE_W-1:0]     in_byte;
  cls_t                  in_cls;
  logic                  tbl_we;
  cls_t                  tbl_rdata;
  logic [TBL_DEPTH-1:0]  tv_q;
  logic                  hit_q;
  logic                  vld_q;
  action_t               act_q;
  logic [BYTE_W-1:0]     byte_q;

  assign in_byte       = s_axis_tdata[BYTE_W-1:0];
  assign in_cls        = s_axis_tdata[BYTE_W+CLS_W-1:BYTE_W];
  assign s_axis_tready = !vld_q || fire_i;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign tbl_we        = acc && (s_axis_tuser == ACT_LOAD);

  cct_ram #(
    .WIDTH (CLS_W),
    .DEPTH (TBL_DEPTH)
  ) u_tbl (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (in_byte),
    .wdata_i (in_cls),
    .re_i    (acc),
    .raddr_i (in_byte),
    .rdata_o (tbl_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q  <= '0;
      vld_q <= 1'b0;
    end else begin
      if (tbl_we) begin
        tv_q[in_byte] <= 1'b1;
      end
      if (acc) begin
        vld_q <= 1'b1;
      end else if (fire_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      act_q  <= s_axis_tuser;
      byte_q <= in_byte;
      hit_q  <= tv_q[in_byte];
    end
  end

  // never-written entries read as letter
  assign item_vld_o       = vld_q;
  assign item_o.action    = act_q;
  assign item_o.char_byte = byte_q;
  assign item_o.cls       = hit_q ? tbl_rdata : CLS_LETTER;

endmodule

`default_nettype wire

/* rtl/core/cct_engine.sv */
// tokenizer line state and the single-pass per-item result logic
// depends on cct_pkg
`default_nettype none

module cct_engine import cct_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            fire_i,
  input  wire item_t           item_i,
  output res_arr_t             res_o,
  output logic [RES_CW-1:0]    nres_o
);

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [COL_W-1:0]  col;
    logic              swap;
    logic              quote;
    logic              fresh;
    logic [BYTE_W-1:0] prev;
    logic              ovf;
  } st_t;

  localparam st_t ST_RESET = '{slot: '0, col: '0, swap: 1'b0, quote: 1'b0,
                               fresh: 1'b1, prev: '0, ovf: 1'b0};

  st_t               st_q, st_d;
  res_arr_t          res;
  logic [RES_CW-1:0] n;

  function automatic void put(inout st_t s, inout res_arr_t r, inout logic [RES_CW-1:0] k,
                              input logic [SLOT_W-1:0] sl, input logic [COL_W-1:0] c,
                              input logic [BYTE_W-1:0] v);
    if (sl >= SLOT_W'(MAX_TOKENS)) begin
      s.ovf = 1'b1;
    end else if (c < COL_W'(TOKEN_LEN) && k < RES_CW'(MAX_RES)) begin
      r[k[RES_IW-1:0]].kind     = KIND_WRITE;
      r[k[RES_IW-1:0]].slot     = sl[SLOT_FW-1:0];
      r[k[RES_IW-1:0]].column   = c[COL_FW-1:0];
      r[k[RES_IW-1:0]].value    = v;
      r[k[RES_IW-1:0]].tok_cnt  = '0;
      k = k + RES_CW'(1);
    end
  endfunction

  function automatic void next_slot(inout st_t s);
    if (s.slot < SLOT_W'(MAX_TOKENS)) begin
      s.slot = s.slot + SLOT_W'(1);
    end
  endfunction

  function automatic void put_byte(inout st_t s, inout res_arr_t r,
                                   inout logic [RES_CW-1:0] k, input logic [BYTE_W-1:0] b);
    put(s, r, k, s.slot, s.col, b);
    if (s.col < COL_W'(TOKEN_LEN)) begin
      s.col = s.col + COL_W'(1);
    end
  endfunction

  function automatic void close_slot(inout st_t s, inout res_arr_t r,
                                     inout logic [RES_CW-1:0] k);
    put(s, r, k, s.slot, s.col, '0);
    next_slot(s);
    s.col = '0;
  endfunction

  function automatic void process(inout st_t s, inout res_arr_t r,
                                  inout logic [RES_CW-1:0] k,
                                  input logic [BYTE_W-1:0] b, input cls_t c);
    if (c == CLS_QUOTE && s.prev == BACKSLASH) begin
      // escaped quote is plain text, skips the full-token check
      put_byte(s, r, k, b);
    end else if (c <= CLS_QUOTE) begin
      if (s.col >= COL_W'(TOKEN_LEN)) begin
        put(s, r, k, s.slot, COL_W'(TOKEN_LEN - 1), '0);
        next_slot(s);
        s.col   = '0;
        s.fresh = 1'b1;
      end
      if (c != CLS_QUOTE && s.quote) begin
        put_byte(s, r, k, b);
      end else begin
        case (c)
          CLS_LETTER: begin
            if (s.swap) begin
              s.swap = 1'b0;
              if (!s.fresh) begin
                close_slot(s, r, k);
                s.fresh = 1'b1;
              end
            end
            put_byte(s, r, k, b);
            s.fresh = 1'b0;
          end
          CLS_IGNORE: begin
            if (!s.fresh) begin
              next_slot(s);
              s.col   = '0;
              s.fresh = 1'b1;
            end
          end
          CLS_DELIM: begin
            if (!s.fresh) begin
              close_slot(s, r, k);
            end
            put_byte(s, r, k, b);
            close_slot(s, r, k);
            s.fresh = 1'b1;
          end
          CLS_SWAP: begin
            if (!s.swap) begin
              s.swap = 1'b1;
              if (!s.fresh) begin
                close_slot(s, r, k);
                s.fresh = 1'b1;
              end
            end
            put_byte(s, r, k, b);
            s.fresh = 1'b0;
          end
          default: begin
            if (!s.fresh) begin
              close_slot(s, r, k);
            end
            put_byte(s, r, k, b);
            if (s.quote) begin
              close_slot(s, r, k);
              s.fresh = 1'b1;
            end
            s.quote = !s.quote;
          end
        endcase
      end
    end
  endfunction

  always_comb begin
    st_d = st_q;
    res  = '0;
    n    = '0;
    case (item_i.action)
      ACT_BYTE: begin
        if (item_i.char_byte != '0) begin
          process(st_d, res, n, item_i.char_byte, item_i.cls);
          st_d.prev = item_i.char_byte;
        end
      end
      ACT_EOL: begin
        if (st_d.col != '0) begin
          put(st_d, res, n, st_d.slot, COL_W'(TOKEN_LEN - 1), '0);
          next_slot(st_d);
          st_d.col = '0;
        end
        if (n < RES_CW'(MAX_RES)) begin
          res[n[RES_IW-1:0]].kind = KIND_REPORT;
          if (32'(st_d.slot) > 32'(CNT_MAX)) begin
            res[n[RES_IW-1:0]].tok_cnt = CNT_FW'(CNT_MAX);
          end else begin
            res[n[RES_IW-1:0]].tok_cnt = CNT_FW'(st_d.slot);
          end
          n = n + RES_CW'(1);
        end
      end
      default: ;
    endcase
    for (int i = 0; i < MAX_RES; i++) begin
      res[i].overflow = st_d.ovf;
      res[i].last     = (RES_CW'(i) == n - RES_CW'(1));
    end
    if (item_i.action == ACT_EOL) begin
      st_d = ST_RESET;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_RESET;
    end else if (fire_i) begin
      st_q <= st_d;
    end
  end

  assign res_o  = res;
  assign nres_o = n;

endmodule

`default_nettype wire

/* rtl/core/cct_outbuf.sv */
// result buffer: holds the results of one item and hands them out one per transfer
// depends on cct_pkg and the assertion macro header
`default_nettype none
`include "char_class_tokenizer_top_macros.svh"

module cct_outbuf import cct_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire res_arr_t          res_i,
  input  wire logic [RES_CW-1:0] nres_i,
  output logic                   load_ok_o,
  output logic                   m_vld_o,
  input  wire logic              m_rdy_i,
  output res_t                   m_res_o
);

  res_arr_t          buf_q;
  logic [RES_CW-1:0] cnt_q;
  logic [RES_IW-1:0] head_q;
  logic              pop;

  assign m_vld_o   = (cnt_q != '0);
  assign pop       = m_vld_o && m_rdy_i;
  assign load_ok_o = (cnt_q == '0) || (cnt_q == RES_CW'(1) && m_rdy_i);
  assign m_res_o   = buf_q[head_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      head_q <= '0;
    end else if (load_i) begin
      cnt_q  <= nres_i;
      head_q <= '0;
    end else if (pop) begin
      cnt_q  <= cnt_q - RES_CW'(1);
      head_q <= head_q + RES_IW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q <= res_i;
    end
  end

  `CCT_ASSERT(a_load_only_when_drained,
    load_i |-> (cnt_q == '0 || (cnt_q == RES_CW'(1) && m_rdy_i)),
    "result buffer overwritten with results pending")
  `CCT_ASSERT(a_pop_counts_down,
    (pop && !load_i) |=> (cnt_q == $past(cnt_q) - RES_CW'(1)),
    "result count did not follow a transfer")
  `CCT_ASSERT(a_final_entry_is_last,
    (cnt_q == RES_CW'(1)) |-> buf_q[head_q].last,
    "final buffered result lacks the last mark")

endmodule

`default_nettype wire

/* rtl/core/char_class_tokenizer_top.sv */
// top level of the character class tokenizer
// depends on cct_pkg, cct_front, cct_engine, cct_outbuf
//
// channel   dir  tuser           tdata (low bit first)                      tlast
// s_axis    in   action[1:0]     char_byte[7:0], class_code[10:8], 0 pad   -
// m_axis    out  kind[0]         slot[7:0], column[13:8], value[21:14],   last
//                                tok_cnt[30:22], overflow[31]
//
// one input transfer per cycle when each item yields at most one result and m_axis_tready
// stays high; an item yielding k results holds the output for k transfers (k at most four)
// an input transfer is registered in the item register, then in the result buffer, before m_axis
// the class table is a 256 x 3 ram, never-loaded entries read as letter through
// per-entry valid bits cleared at reset, so no clearing pass is needed
// reset: rst_ni asynchronous, active low; clears line state and the valid bits
// output stalls back up through the item register to s_axis_tready
`default_nettype none

module char_class_tokenizer_top import cct_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // input channel
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // char_byte, class_code
  input  wire logic [ACT_W-1:0]       s_axis_tuser,   // action
  // result channel
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // slot, column, value, tok_cnt, overflow
  output logic [0:0]                  m_axis_tuser,   // kind
  output logic                        m_axis_tlast    // final result of the item
);

  logic              item_vld;
  item_t             item;
  logic              load_ok;
  logic              fire;
  res_arr_t          res;
  logic [RES_CW-1:0] nres;
  res_t              head;

  // the item in the register executes once the result buffer can take its results
  assign fire = item_vld && load_ok;

  // class lookup and item register
  cct_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .fire_i        (fire),
    .item_vld_o    (item_vld),
    .item_o        (item)
  );

  // line state and result generation
  cct_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item),
    .res_o  (res),
    .nres_o (nres)
  );

  // result register, one transfer per result
  cct_outbuf u_outbuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (fire),
    .res_i     (res),
    .nres_i    (nres),
    .load_ok_o (load_ok),
    .m_vld_o   (m_axis_tvalid),
    .m_rdy_i   (m_axis_tready),
    .m_res_o   (head)
  );

  // pack result fields, lowest first
  assign m_axis_tdata = {head.overflow, head.tok_cnt, head.value, head.column, head.slot};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule

`default_nettype wire

/* verif/cct_checker.sv */
`timescale 1ns / 100ps
// result checker for the character class tokenizer: follows both stream channels,
// predicts each token store write and line report, and compares them in order
// depends on cct_pkg
module cct_checker import cct_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // char_byte, class_code
  input  logic [ACT_W-1:0]       s_axis_tuser,   // action
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,   // slot, column, value, tok_cnt, overflow
  input  logic [0:0]             m_axis_tuser,   // kind
  input  logic                   m_axis_tlast,
  output int                     fail_count_o,
  output int                     pending_o
);

  localparam int COL_LSB = SLOT_FW;
  localparam int VAL_LSB = COL_LSB + COL_FW;
  localparam int CNT_LSB = VAL_LSB + BYTE_W;
  localparam int OVF_BIT = CNT_LSB + CNT_FW;

  // tokenizer state as the block should hold it
  cls_t              cls_tbl [TBL_DEPTH];
  logic [SLOT_W-1:0] slot_q;
  logic [COL_W-1:0]  col_q;
  logic              swap_q;
  logic              quote_q;
  logic              fresh_q;
  logic              ovf_q;
  logic [BYTE_W-1:0] prev_q;

  res_t item_res [MAX_RES];
  int   item_n;
  res_t store_ops_q [$];
  int   mism_n;

  function automatic void push_op(logic kind, int s, int c, int v, int cnt);
    if (item_n < MAX_RES) begin
      item_res[item_n].kind     = kind;
      item_res[item_n].slot     = s[SLOT_FW-1:0];
      item_res[item_n].column   = c[COL_FW-1:0];
      item_res[item_n].value    = v[BYTE_W-1:0];
      item_res[item_n].tok_cnt  = cnt[CNT_FW-1:0];
      item_res[item_n].overflow = 1'b0;
      item_res[item_n].last     = 1'b0;
      item_n++;
    end
  endfunction

  // writes past the last slot only raise the overflow flag, past the last column vanish
  function automatic void store_write(int s, int c, int v);
    if (s >= MAX_TOKENS) begin
      ovf_q = 1'b1;
    end else if (c < TOKEN_LEN) begin
      push_op(KIND_WRITE, s, c, v, 0);
    end
  endfunction

  function automatic void advance_slot();
    if (slot_q < MAX_TOKENS) slot_q++;
  endfunction

  function automatic void append_byte(logic [BYTE_W-1:0] b);
    store_write(slot_q, col_q, b);
    if (col_q < TOKEN_LEN) col_q++;
  endfunction

  function automatic void terminate_token();
    store_write(slot_q, col_q, 0);
    advance_slot();
    col_q = '0;
  endfunction

  function automatic void line_clear();
    slot_q  = '0;
    col_q   = '0;
    swap_q  = 1'b0;
    quote_q = 1'b0;
    fresh_q = 1'b1;
    prev_q  = '0;
    ovf_q   = 1'b0;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mism_n++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic [BYTE_W-1:0] b;
    cls_t              cls;
    res_t              got;
    res_t              want;
    if (!rst_ni) begin
      foreach (cls_tbl[i]) cls_tbl[i] = CLS_LETTER;
      line_clear();
      store_ops_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        b      = s_axis_tdata[BYTE_W-1:0];
        item_n = 0;
        case (s_axis_tuser)
          ACT_LOAD: cls_tbl[b] = s_axis_tdata[BYTE_W +: CLS_W];
          ACT_BYTE: if (b != '0) begin
            cls = cls_tbl[b];
            if (cls == CLS_QUOTE && prev_q == BACKSLASH) begin
              append_byte(b);
            end else if (cls <= CLS_QUOTE) begin
              if (col_q >= TOKEN_LEN) begin
                store_write(slot_q, TOKEN_LEN - 1, 0);
                advance_slot();
                col_q   = '0;
                fresh_q = 1'b1;
              end
              if (cls != CLS_QUOTE && quote_q) begin
                append_byte(b);
              end else begin
                case (cls)
                  CLS_LETTER: begin
                    if (swap_q) begin
                      swap_q = 1'b0;
                      if (!fresh_q) begin
                        terminate_token();
                        fresh_q = 1'b1;
                      end
                    end
                    append_byte(b);
                    fresh_q = 1'b0;
                  end
                  CLS_IGNORE: if (!fresh_q) begin
                    advance_slot();
                    col_q   = '0;
                    fresh_q = 1'b1;
                  end
                  CLS_DELIM: begin
                    if (!fresh_q) terminate_token();
                    append_byte(b);
                    terminate_token();
                    fresh_q = 1'b1;
                  end
                  CLS_SWAP: begin
                    if (!swap_q) begin
                      swap_q = 1'b1;
                      if (!fresh_q) begin
                        terminate_token();
                        fresh_q = 1'b1;
                      end
                    end
                    append_byte(b);
                    fresh_q = 1'b0;
                  end
                  default: begin
                    if (!fresh_q) terminate_token();
                    append_byte(b);
                    if (quote_q) begin
                      terminate_token();
                      fresh_q = 1'b1;
                    end
                    quote_q = !quote_q;
                  end
                endcase
              end
            end
            prev_q = b;
          end
          ACT_EOL: begin
            if (col_q != '0) begin
              store_write(slot_q, TOKEN_LEN - 1, 0);
              advance_slot();
              col_q = '0;
            end
            push_op(KIND_REPORT, 0, 0, 0, (slot_q > CNT_MAX) ? CNT_MAX : int'(slot_q));
          end
          default: ;
        endcase
        for (int k = 0; k < item_n; k++) begin
          item_res[k].overflow = ovf_q;
          item_res[k].last     = (k == item_n - 1);
          store_ops_q.push_back(item_res[k]);
        end
        if (s_axis_tuser == ACT_EOL) line_clear();
      end

      if (m_axis_tvalid && m_axis_tready) begin
        got.kind     = m_axis_tuser[0];
        got.slot     = m_axis_tdata[SLOT_FW-1:0];
        got.column   = m_axis_tdata[COL_LSB +: COL_FW];
        got.value    = m_axis_tdata[VAL_LSB +: BYTE_W];
        got.tok_cnt  = m_axis_tdata[CNT_LSB +: CNT_FW];
        got.overflow = m_axis_tdata[OVF_BIT];
        got.last     = m_axis_tlast;
        if (store_ops_q.size() == 0) begin
          $error("result with nothing predicted: kind %0d tdata %h", got.kind, m_axis_tdata);
          mism_n++;
        end else begin
          want = store_ops_q.pop_front();
          check_field("kind", want.kind, got.kind);
          check_field("slot", want.slot, got.slot);
          check_field("column", want.column, got.column);
          check_field("value", want.value, got.value);
          check_field("tok_cnt", want.tok_cnt, got.tok_cnt);
          check_field("overflow", want.overflow, got.overflow);
          check_field("last", want.last, got.last);
        end
      end
    end
    fail_count_o <= mism_n;
    pending_o    <= store_ops_q.size();
  end

endmodule

/* verif/char_class_tokenizer_top_tb.sv */
`timescale 1ns / 100ps
// stimulus top for the character class tokenizer: clock, reset, byte traffic and verdict
// depends on cct_pkg, char_class_tokenizer_top and cct_checker
module char_class_tokenizer_top_tb;
  import cct_pkg::*;

  // action code the block does not know, it must drop the transfer
  localparam action_t ACT_NONE = 2'd3;
  // class code beyond the defined ones, bytes of it only update the previous byte
  localparam cls_t    CLS_DEAD = 3'd7;

  // byte roles set up by the directed loads and never reloaded afterwards
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_DEAD  = 8'hFF;

  localparam int RANDOM_ITEMS = 500;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PATTERN, RX_CHOKE} rx_mode_e;

  logic                   clk_i  = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;        // char_byte, class_code, zero pad
  logic [ACT_W-1:0]       s_axis_tuser  = ACT_LOAD;  // action
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;              // slot, column, value, tok_cnt, overflow
  logic [0:0]             m_axis_tuser;              // kind
  logic                   m_axis_tlast;

  int fails;
  int pending;

  // sender burst bookkeeping and count of items that do real work
  int burst_left = 0;
  int sent_items = 0;

  // receiver stall pattern state
  rx_mode_e          rx_mode = RX_OPEN;
  int                rx_left = 0;
  logic [7:0]        rx_pat  = '0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  char_class_tokenizer_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  cct_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fails),
    .pending_o     (pending)
  );

  // receiver: each stretch picks a stall style, from never stalling to mostly stalled
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 200);
      rx_pat  <= 8'($urandom);
    end else begin
      rx_left <= rx_left - 1;
      rx_pat  <= {rx_pat[6:0], rx_pat[7]};
    end
    case (rx_mode)
      RX_OPEN:    m_axis_tready <= 1'b1;
      RX_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
      RX_PATTERN: m_axis_tready <= rx_pat[0];
      default:    m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // one input transfer; a burst that runs out first drops tvalid for a random gap,
  // and a quarter of the bursts follow on with no gap at all
  task automatic send(action_t act, logic [BYTE_W-1:0] b, cls_t c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - BYTE_W - CLS_W){1'b0}}, c, b};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    // byte zero and the unknown action are dropped by the block, they do not count
    if (act == ACT_LOAD || act == ACT_EOL || (act == ACT_BYTE && b != '0)) sent_items++;
  endtask

  // byte item; the class field is don't-care here so it carries random bits
  task automatic feed(logic [BYTE_W-1:0] b);
    send(ACT_BYTE, b, cls_t'($urandom_range(0, 7)));
  endtask

  task automatic end_line();
    send(ACT_EOL, 8'($urandom_range(0, 255)), cls_t'($urandom_range(0, 7)));
  endtask

  // letters from both cases, with a backslash now and then
  task automatic feed_word(int n);
    repeat (n) begin
      if ($urandom_range(0, 11) == 0) feed("\\");
      else if ($urandom_range(0, 1) != 0) feed(8'($urandom_range(8'h61, 8'h7A)));
      else feed(8'($urandom_range(8'h41, 8'h5A)));
    end
  endtask

  // quoted run of arbitrary bytes, with escaped quotes mixed in; may be left open
  task automatic feed_quoted(int n, bit closed);
    feed(CH_QUOTE);
    repeat (n) begin
      if ($urandom_range(0, 5) == 0) begin
        feed("\\");
        feed(CH_QUOTE);
      end else begin
        feed(8'($urandom_range(1, 255)));
      end
    end
    if (closed) feed(CH_QUOTE);
  endtask

  initial begin
    int roll;
    int slots;
    int guard;
    bit flooded;
    flooded = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // class setup: two ignorable, two delimiters, two swap bytes, the quote,
    // and one byte with an undefined class
    send(ACT_LOAD, CH_SPACE, CLS_IGNORE);
    send(ACT_LOAD, CH_TAB,   CLS_IGNORE);
    send(ACT_LOAD, CH_COMMA, CLS_DELIM);
    send(ACT_LOAD, CH_SEMI,  CLS_DELIM);
    send(ACT_LOAD, CH_PLUS,  CLS_SWAP);
    send(ACT_LOAD, CH_MINUS, CLS_SWAP);
    send(ACT_LOAD, CH_QUOTE, CLS_QUOTE);
    send(ACT_LOAD, CH_DEAD,  CLS_DEAD);

    // letter, swap run closing it, letter closing the swap run
    feed("a");
    feed(CH_PLUS);
    feed(CH_MINUS);
    feed("b");
    // delimiter after an open token, then an ignorable byte
    feed(CH_COMMA);
    feed(CH_SPACE);
    // quoted run holding a space, a backslash and an escaped quote
    feed(CH_QUOTE);
    feed(CH_SPACE);
    feed("\\");
    feed(CH_QUOTE);
    feed(CH_QUOTE);
    // string end mark, undefined class byte, unknown action
    feed(8'h00);
    feed(CH_DEAD);
    send(ACT_NONE, 8'hA5, CLS_LETTER);
    end_line();

    // random part: mostly well formed lines, plus long tokens, one slot flood,
    // class reloads of the upper byte range and raw noise
    while (sent_items < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (!flooded && sent_items > 80) begin
        // run the slot index past its limit; later writes must be dropped and flagged
        flooded = 1'b1;
        end_line();
        slots = 0;
        while (slots < 262) begin
          if ($urandom_range(0, 2) == 0) begin
            feed_word(1);
            slots++;
          end
          feed(($urandom_range(0, 1) != 0) ? CH_COMMA : CH_SEMI);
          slots++;
        end
        feed_word(3);
        end_line();
      end else if (roll < 8) begin
        // long tokens near or past the column limit; the first variant puts an escaped quote
        // right past the last column
        end_line();
        case ($urandom_range(0, 2))
          0: begin
            repeat (63) feed("x");
            feed("\\");
            feed(CH_QUOTE);
            feed_word($urandom_range(0, 4));
          end
          1: feed_word($urandom_range(60, 70));
          default: feed_quoted($urandom_range(60, 70), 1'b1);
        endcase
        if ($urandom_range(0, 1) != 0) feed(CH_COMMA);
        end_line();
      end else if (roll < 14) begin
        repeat ($urandom_range(1, 4))
          send(ACT_LOAD, 8'($urandom_range(8'h80, 8'hFE)), cls_t'($urandom_range(0, 7)));
      end else if (roll < 22) begin
        // noise: any action, any byte; loads stay off the bytes with fixed roles
        repeat ($urandom_range(2, 8)) begin
          case ($urandom_range(0, 3))
            0: send(ACT_LOAD, 8'($urandom_range(8'h80, 8'hFE)), cls_t'($urandom_range(0, 7)));
            1: feed(8'($urandom_range(0, 255)));
            2: send(ACT_NONE, 8'($urandom_range(0, 255)), cls_t'($urandom_range(0, 7)));
            default: end_line();
          endcase
        end
      end else begin
        repeat ($urandom_range(1, 12)) begin
          roll = $urandom_range(0, 99);
          if (roll < 35) feed_word($urandom_range(1, 8));
          else if (roll < 50) feed(($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB);
          else if (roll < 62) feed(($urandom_range(0, 1) != 0) ? CH_COMMA : CH_SEMI);
          else if (roll < 74) begin
            repeat ($urandom_range(1, 3)) feed(($urandom_range(0, 1) != 0) ? CH_PLUS : CH_MINUS);
          end else if (roll < 86) feed_quoted($urandom_range(0, 6), $urandom_range(0, 7) != 0);
          else if (roll < 94) feed(8'($urandom_range(8'h80, 8'hFE)));
          else feed(8'($urandom_range(0, 255)));
        end
        // now and then a line runs on into the next without a flush
        if ($urandom_range(0, 9) != 0) end_line();
      end
    end
    end_line();
    s_axis_tvalid <= 1'b0;

    // drain: wait for every predicted result, then keep waiting a while for strays
    guard = 0;
    do begin
      @(posedge clk_i);
      guard++;
    end while (pending != 0 && guard < 100000);
    repeat (8) @(posedge clk_i);
    if (pending != 0) $error("%0d predicted results never arrived", pending);
    if (fails == 0 && pending == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
